@@ hw/rtl/trli_pkg.sv @@
// -----------------------------------------------------------------------------
// trli_pkg
// Shared types and constants for the two-way row tag table with LRU insert.
// -----------------------------------------------------------------------------
package trli_pkg;

   localparam int ROW_BITS          = 14;
   localparam int SET_COUNT_DEFAULT = 32;

   typedef struct packed {
      logic [ROW_BITS-1:0] row_address;
      logic                end_of_batch;
   } trli_req_type;

   typedef struct packed {
      logic hit;
      logic way_written;
      logic batch_end;
   } trli_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_MOD,
      ST_READ,
      ST_UPDATE
   } trli_state_type;

   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic mul_step;
      logic mod_step;
      logic read_step;
      logic update_step;
   } trli_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } trli_status_type;

endpackage

@@ hw/rtl/trli_ctrl.sv @@
// -----------------------------------------------------------------------------
// trli_ctrl
// Sequencer: clears the table after reset, then steps each request through
// set index calculation, table read and table update.
// -----------------------------------------------------------------------------
module trli_ctrl
   import trli_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  trli_status_type status,
   output trli_cmd_type    cmd
);

   trli_state_type state_ff;
   trli_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = ST_MOD;
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            state_in     = ST_READ;
         end
         ST_READ: begin
            cmd.read_step = 1'b1;
            state_in      = ST_UPDATE;
         end
         ST_UPDATE: begin
            // The result register must be free before the table is written.
            if (status.out_free) begin
               cmd.update_step = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

@@ hw/rtl/trli_datapath.sv @@
// -----------------------------------------------------------------------------
// trli_datapath
// Set index calculation, tag table memory, hit check, LRU update and the
// result register.
// -----------------------------------------------------------------------------
module trli_datapath
   import trli_pkg::*;
#(
   parameter int SET_COUNT = SET_COUNT_DEFAULT
)
(
   input  logic            clock,
   input  logic            reset,
   input  trli_cmd_type    cmd,
   output trli_status_type status,
   input  trli_req_type    req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output trli_rsp_type    rsp_data
);

   localparam int SET_BITS   = $clog2(SET_COUNT);
   localparam int SHIFT      = ROW_BITS + SET_BITS;
   localparam int RECIP      = (2 ** SHIFT) / SET_COUNT;
   localparam int WIDE_BITS  = ROW_BITS + 1;
   localparam int PROD_BITS  = ROW_BITS + WIDE_BITS;
   localparam int QUOT_BITS  = PROD_BITS - SHIFT;
   localparam int WAY_BITS   = ROW_BITS + 1;
   localparam int ENTRY_BITS = 2 * WAY_BITS + 1;

   // Entry layout: LRU bit, then way 1 (valid, row), then way 0 (valid, row).
   logic [ENTRY_BITS-1:0] set_mem [SET_COUNT];

   logic [SET_BITS-1:0]   clr_cnt_ff;
   logic [ROW_BITS-1:0]   row_ff;
   logic                  eob_ff;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [SET_BITS-1:0]   set_ff;
   logic [ENTRY_BITS-1:0] rd_ff;
   logic                  rsp_valid_ff;
   trli_rsp_type          rsp_data_ff;

   logic [QUOT_BITS-1:0]  quot;
   logic [WIDE_BITS-1:0]  quot_times;
   logic [WIDE_BITS-1:0]  rem_raw;
   logic [WIDE_BITS-1:0]  rem_fix;
   logic                  lru;
   logic                  valid0;
   logic                  valid1;
   logic [ROW_BITS-1:0]   row0;
   logic [ROW_BITS-1:0]   row1;
   logic                  hit0;
   logic                  hit1;
   logic                  sel;
   logic [ENTRY_BITS-1:0] entry_in;

   // The reciprocal estimate of the quotient is at most one too small, so
   // a single compare and subtract gives the exact remainder.
   always_comb begin
      quot       = prod_ff[PROD_BITS-1:SHIFT];
      quot_times = WIDE_BITS'(quot) * WIDE_BITS'(SET_COUNT);
      rem_raw    = WIDE_BITS'(row_ff) - quot_times;
      if (rem_raw >= WIDE_BITS'(SET_COUNT)) begin
         rem_fix = rem_raw - WIDE_BITS'(SET_COUNT);
      end else begin
         rem_fix = rem_raw;
      end
   end

   always_comb begin
      lru    = rd_ff[ENTRY_BITS-1];
      valid1 = rd_ff[2*WAY_BITS-1];
      row1   = rd_ff[2*WAY_BITS-2:WAY_BITS];
      valid0 = rd_ff[WAY_BITS-1];
      row0   = rd_ff[ROW_BITS-1:0];
      hit0   = valid0 && (row0 == row_ff);
      hit1   = valid1 && (row1 == row_ff);
      if (hit1) begin
         sel = 1'b1;
      end else if (hit0) begin
         sel = 1'b0;
      end else begin
         sel = lru;
      end
      if (sel) begin
         entry_in = {1'b0, 1'b1, row_ff, valid0, row0};
      end else begin
         entry_in = {1'b1, valid1, row1, 1'b1, row_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         row_ff <= req_data.row_address;
         eob_ff <= req_data.end_of_batch;
      end
      if (cmd.mul_step) begin
         prod_ff <= PROD_BITS'(row_ff) * PROD_BITS'(RECIP);
      end
      if (cmd.mod_step) begin
         set_ff <= rem_fix[SET_BITS-1:0];
      end
      if (cmd.read_step) begin
         rd_ff <= set_mem[set_ff];
      end
      if (cmd.update_step) begin
         rsp_data_ff.hit         <= hit0 || hit1;
         rsp_data_ff.way_written <= sel;
         rsp_data_ff.batch_end   <= eob_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         set_mem[clr_cnt_ff] <= '0;
      end else if (cmd.update_step) begin
         set_mem[set_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + SET_BITS'(1);
         end
         if (cmd.update_step) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.clear_last = (clr_cnt_ff == SET_BITS'(SET_COUNT - 1));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.update_step |-> (!rsp_valid_ff || !rsp_stall))
      else $error("Pending result overwritten by a table update.");

   a_set_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.read_step |-> (32'(set_ff) < 32'(SET_COUNT)))
      else $error("Set index out of range at table read.");

   a_update_gives_result: assert property (@(posedge clock) disable iff (reset)
      cmd.update_step |=> rsp_valid_ff)
      else $error("Table update did not present a result.");

   a_clear_idle_output: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> (!rsp_valid_ff && !cmd.update_step))
      else $error("Result activity during the clearing pass.");
`endif

endmodule

@@ hw/rtl/two_way_row_tag_insert_lru.sv @@
// -----------------------------------------------------------------------------
// two_way_row_tag_insert_lru
// Two-way set-associative row tag table with LRU replacement, insert on
// precharge.
// -----------------------------------------------------------------------------
// Usage:
// Each request carries one DRAM row address and a batch-end marker. The row
// selects a set (row modulo SET_COUNT) and is inserted into that set: a hit
// in way 1 rewrites way 1, else a hit in way 0 rewrites way 0, else the LRU
// way is replaced. The written way becomes most recently used.
// Each request gives exactly one result: hit flag, way written, batch end.
// The request passes through multiply, remainder, table read and table
// update before the result is registered. One request is worked on at a
// time, so the next request is taken only once the sequencer is idle
// again after the table update of the last one.
// After reset the table is cleared one set per cycle, during which
// req_stall stays high.
// The result is held in an output register. If the receiver stalls, the
// next request is still taken and processed, but its table update waits
// until the held result has been taken.
// -----------------------------------------------------------------------------
module two_way_row_tag_insert_lru
   import trli_pkg::*;
#(
   parameter int SET_COUNT = SET_COUNT_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  trli_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output trli_rsp_type rsp_data
);

   trli_cmd_type    cmd;
   trli_status_type status;

   trli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   trli_datapath #(
      .SET_COUNT (SET_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/two_way_row_tag_insert_lru_test.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// two_way_row_tag_insert_lru_test
// Self-checking bench for the two-way row tag table with LRU insert. A
// scoreboard keeps its own copy of the tag table and predicts the hit flag,
// the way written and the batch marker of each request, then checks every
// response in order. Directed requests cover cold sets, hits in each way and
// LRU eviction; random requests favour recently used rows and a few busy
// sets, under several patterns of sender idling and receiver stalling.
// -----------------------------------------------------------------------------
module two_way_row_tag_insert_lru_test;
   import trli_pkg::*;

   localparam int SET_COUNT       = SET_COUNT_DEFAULT;
   localparam int RANDOM_REQUESTS = 1350;
   localparam int PHASE_COUNT     = 4;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 12;
   localparam int TAGS_PER_SET    = (1 << ROW_BITS) / SET_COUNT;

   class tag_table_scoreboard;
      bit                  way_valid [2][SET_COUNT];
      logic [ROW_BITS-1:0] way_row [2][SET_COUNT];
      bit                  lru_way [SET_COUNT];
      trli_rsp_type        expected_q [$];
      int                  error_count;

      function new();
         for (int s = 0; s < SET_COUNT; s++) begin
            way_valid[0][s] = 1'b0;
            way_valid[1][s] = 1'b0;
            way_row[0][s]   = '0;
            way_row[1][s]   = '0;
            lru_way[s]      = 1'b0;
         end
         error_count = 0;
      endfunction

      function void note_request(trli_req_type req);
         int unsigned  set_index;
         bit           hit0;
         bit           hit1;
         bit           sel;
         trli_rsp_type rsp;
         set_index = int'(req.row_address) % SET_COUNT;
         hit0 = way_valid[0][set_index] && (way_row[0][set_index] == req.row_address);
         hit1 = way_valid[1][set_index] && (way_row[1][set_index] == req.row_address);
         // Way 1 takes priority on a hit; a miss replaces the LRU way.
         if (hit1) begin
            sel = 1'b1;
         end else if (hit0) begin
            sel = 1'b0;
         end else begin
            sel = lru_way[set_index];
         end
         way_valid[sel][set_index] = 1'b1;
         way_row[sel][set_index]   = req.row_address;
         lru_way[set_index]        = ~sel;
         rsp.hit         = hit0 | hit1;
         rsp.way_written = sel;
         rsp.batch_end   = req.end_of_batch;
         expected_q.push_back(rsp);
      endfunction

      function void check_response(trli_rsp_type got);
         trli_rsp_type exp;
         if (expected_q.size() == 0) begin
            $display("%0t: response with none expected: actual %b", $time, got);
            error_count++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.hit !== exp.hit) begin
            $display("%0t: hit mismatch: expected %b actual %b", $time, exp.hit, got.hit);
            error_count++;
         end
         if (got.way_written !== exp.way_written) begin
            $display("%0t: way_written mismatch: expected %b actual %b",
                     $time, exp.way_written, got.way_written);
            error_count++;
         end
         if (got.batch_end !== exp.batch_end) begin
            $display("%0t: batch_end mismatch: expected %b actual %b",
                     $time, exp.batch_end, got.batch_end);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   trli_req_type        req_data  = '0;
   logic                rsp_stall = 1'b0;
   logic                req_stall;
   logic                rsp_valid;
   trli_rsp_type        rsp_data;

   tag_table_scoreboard tag_tracker = new();
   int                  stall_pct   = 0;
   int                  cycle_count = 0;
   logic [ROW_BITS-1:0] recent_rows [$];
   int unsigned         busy_sets [4];

   two_way_row_tag_insert_lru #(
      .SET_COUNT(SET_COUNT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL two_way_row_tag_insert_lru");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         tag_tracker.check_response(rsp_data);
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Valid is only lowered when a gap is actually taken, so it is never
   // lowered and raised within the same time step.
   task automatic send_request(input trli_req_type req, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (req_stall !== 1'b0);
      tag_tracker.note_request(req);
   endtask

   // Most requests revisit recent rows or land in a few busy sets, so that
   // hits in both ways and evictions are frequent.
   function automatic trli_req_type random_request();
      trli_req_type        req;
      int                  pick;
      logic [ROW_BITS-1:0] row;
      pick = $urandom_range(99);
      if (pick < 45 && recent_rows.size() > 0) begin
         row = recent_rows[$urandom_range(recent_rows.size() - 1)];
      end else if (pick < 80) begin
         row = ROW_BITS'($urandom_range(TAGS_PER_SET - 1) * SET_COUNT
                         + busy_sets[$urandom_range(3)]);
      end else begin
         row = ROW_BITS'($urandom_range((1 << ROW_BITS) - 1));
      end
      recent_rows.push_back(row);
      if (recent_rows.size() > 12) begin
         void'(recent_rows.pop_front());
      end
      req.row_address  = row;
      req.end_of_batch = ($urandom_range(7) == 0);
      return req;
   endfunction

   initial begin
      int           directed_rows [18];
      int           idle_pct;
      trli_req_type req;
      // Cold miss on row 0, hits in each way, eviction of the LRU way, the
      // top row and alternating bit patterns.
      directed_rows = '{0, 0, 32, 32, 0, 64, 64, 0, 5, 37, 69, 5,
                        16383, 16383, 16351, 16319, 10922, 5461};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 18; i++) begin
         req.row_address  = ROW_BITS'(directed_rows[i]);
         req.end_of_batch = (i % 4 == 3);
         send_request(req, 0);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 52; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 52; end
            default: begin idle_pct = 13; stall_pct <= 13; end
         endcase
         for (int s = 0; s < 4; s++) begin
            busy_sets[s] = $urandom_range(SET_COUNT - 1);
         end
         for (int i = 0; i < RANDOM_REQUESTS / PHASE_COUNT; i++) begin
            send_request(random_request(), idle_pct);
         end
      end
      req_valid <= 1'b0;
      stall_pct <= 0;

      while (tag_tracker.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tag_tracker.error_count == 0) begin
         $display("PASS two_way_row_tag_insert_lru");
      end else begin
         $display("FAIL two_way_row_tag_insert_lru");
      end
      $finish;
   end

endmodule
